// File: rtl/class_data_record_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Class-data record decoder: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CLASS_DATA_RECORD_DECODER_UNIT_DEFINES_SVH
`define CLASS_DATA_RECORD_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CDRD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdrd check failed");
`define CDRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdrd check failed");
`else
`define CDRD_ASSERT_SAME(lbl, ante, cons)
`define CDRD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/cdrd_pkg.sv
// ----------------------------------------------------------------------------
// Class-data record decoder package
// Shared widths, codes and structs.
// ----------------------------------------------------------------------------
package cdrd_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int LEB_MAX_BYTES = (VALUE_WIDTH + 6) / 7;
  localparam int LEB_SHIFT_W   = $clog2(LEB_MAX_BYTES);
  localparam int NUM_SECTIONS  = 4;
  localparam int SEC_W         = $clog2(NUM_SECTIONS);
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [LEB_SHIFT_W-1:0] leb_shift_t;
  typedef logic [SEC_W-1:0]       sec_t;

  localparam leb_shift_t LEB_LAST = leb_shift_t'(LEB_MAX_BYTES - 1);

  typedef enum logic [2:0] {
    KIND_STATIC   = 3'd0,
    KIND_INSTANCE = 3'd1,
    KIND_DIRECT   = 3'd2,
    KIND_VIRTUAL  = 3'd3,
    KIND_EMPTY    = 3'd4
  } entry_kind_t;

  // Count phases, then one walk phase per section
  typedef enum logic [2:0] {
    PH_CNT0 = 3'd0,
    PH_CNT1 = 3'd1,
    PH_CNT2 = 3'd2,
    PH_CNT3 = 3'd3,
    PH_SEC0 = 3'd4,
    PH_SEC1 = 3'd5,
    PH_SEC2 = 3'd6,
    PH_SEC3 = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    SLOT_DELTA = 2'd0,
    SLOT_FLAGS = 2'd1,
    SLOT_CODE  = 2'd2
  } slot_t;

  typedef struct packed {
    logic   start;
    value_t value;
  } value_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic load_done;
  } back_stat_t;

endpackage

// File: rtl/cdrd_intf.sv
// ----------------------------------------------------------------------------
// Class-data record decoder channel interfaces
// Byte input channel and decoded entry output channel.
// ----------------------------------------------------------------------------
interface cdrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface cdrd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  entry_kind;
  logic [31:0] member_index;
  logic [31:0] member_flags;
  logic [31:0] code_offset;
  logic        record_done;

  modport source (output valid, output entry_kind, output member_index,
                  output member_flags, output code_offset, output record_done,
                  input ready);
  modport sink   (input valid, input entry_kind, input member_index,
                  input member_flags, input code_offset, input record_done,
                  output ready);
endinterface

// File: rtl/cdrd_leb_front.sv
// ----------------------------------------------------------------------------
// LEB128 front end
// Accepts bytes, assembles unsigned LEB128 values and queues each one.
// ----------------------------------------------------------------------------
module cdrd_leb_front (
  input  logic                   clk,
  input  logic                   rst_n,
  cdrd_in_if.sink                in_ch,
  input  cdrd_pkg::fifo_stat_t   q_stat,
  output logic                   push,
  output cdrd_pkg::value_entry_t push_data
);

  cdrd_pkg::value_t     acc_r, acc_nxt;
  cdrd_pkg::leb_shift_t shift_r, shift_nxt;
  logic                 pend_r, pend_nxt;

  cdrd_pkg::value_t     base_acc, ins, merged;
  cdrd_pkg::leb_shift_t base_shift;
  logic                 start_flag, last_byte, accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    base_acc   = in_ch.record_start ? '0 : acc_r;
    base_shift = in_ch.record_start ? '0 : shift_r;
    start_flag = in_ch.record_start || pend_r;
    // bits above the value width fall off the top
    ins        = cdrd_pkg::value_t'(in_ch.data_byte[6:0]) << (7 * int'(base_shift));
    merged     = base_acc | ins;
    last_byte  = !in_ch.data_byte[7] || (base_shift == cdrd_pkg::LEB_LAST);

    acc_nxt         = acc_r;
    shift_nxt       = shift_r;
    pend_nxt        = pend_r;
    push            = 1'b0;
    push_data.start = start_flag;
    push_data.value = merged;
    if (accept) begin
      if (last_byte) begin
        push      = 1'b1;
        acc_nxt   = '0;
        shift_nxt = '0;
        pend_nxt  = 1'b0;
      end else begin
        acc_nxt   = merged;
        shift_nxt = base_shift + 1'b1;
        pend_nxt  = start_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      shift_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// File: rtl/cdrd_value_fifo.sv
// ----------------------------------------------------------------------------
// Value queue
// Short queue of decoded values between the front and back ends.
// ----------------------------------------------------------------------------
module cdrd_value_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  cdrd_pkg::value_entry_t push_data,
  input  logic                   pop,
  output cdrd_pkg::value_entry_t head,
  output cdrd_pkg::fifo_stat_t   q_stat
);

  localparam logic [cdrd_pkg::Q_PTR_W-1:0] PTR_LAST =
    cdrd_pkg::Q_PTR_W'(cdrd_pkg::Q_DEPTH - 1);
  localparam logic [cdrd_pkg::Q_CNT_W-1:0] CNT_FULL =
    cdrd_pkg::Q_CNT_W'(cdrd_pkg::Q_DEPTH);

  cdrd_pkg::value_entry_t             mem_r [cdrd_pkg::Q_DEPTH];
  logic [cdrd_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [cdrd_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [cdrd_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/cdrd_walk_back.sv
// ----------------------------------------------------------------------------
// Record walker
// Consumes decoded values, tracks counts and sections, and registers one
// entry result per completed entry, or one empty-record result.
// ----------------------------------------------------------------------------
module cdrd_walk_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cdrd_pkg::value_entry_t head,
  input  cdrd_pkg::fifo_stat_t   q_stat,
  output logic                   pop,
  cdrd_out_if.source             out_ch,
  output cdrd_pkg::back_stat_t   b_stat
);

  cdrd_pkg::phase_t phase_r, phase_nxt, phase_e;
  cdrd_pkg::slot_t  slot_r, slot_nxt, slot_e;
  logic             first_r, first_nxt, first_e;
  cdrd_pkg::value_t entries_r, entries_nxt, entries_e;
  cdrd_pkg::value_t run_r, run_nxt, run_e;
  cdrd_pkg::value_t held_r, held_nxt, held_e;
  cdrd_pkg::value_t cnt_r [cdrd_pkg::NUM_SECTIONS];

  logic                   ov_r, ov_nxt;
  cdrd_pkg::entry_kind_t  kind_r, res_kind;
  cdrd_pkg::value_t       idx_r, flags_r, code_r, res_idx, res_flags, res_code;
  logic                   done_r, res_done, res_load;

  logic                   cnt_we;
  cdrd_pkg::sec_t         cnt_wa, sec;
  cdrd_pkg::value_t       cnt_view [cdrd_pkg::NUM_SECTIONS];
  logic [cdrd_pkg::SEC_W:0] from;
  logic                   sel_found, idle_e, can_take;
  cdrd_pkg::sec_t         sel_sec;
  cdrd_pkg::value_t       sel_cnt;

  assign can_take = !ov_r || out_ch.ready;
  assign pop      = !q_stat.empty && can_take;

  // effective state: a record start resets the phase, slot and running values first
  always_comb begin
    if (head.start) begin
      phase_e   = cdrd_pkg::PH_CNT0;
      slot_e    = cdrd_pkg::SLOT_DELTA;
      first_e   = 1'b0;
      entries_e = '0;
      run_e     = '0;
      held_e    = '0;
    end else begin
      phase_e   = phase_r;
      slot_e    = slot_r;
      first_e   = first_r;
      entries_e = entries_r;
      run_e     = run_r;
      held_e    = held_r;
    end
    sec    = phase_e[cdrd_pkg::SEC_W-1:0];
    idle_e = (phase_e == cdrd_pkg::PH_SEC3) && (entries_e == '0);
  end

  // next non-empty section; the last count is bypassed while it is written
  always_comb begin
    for (int s = 0; s < cdrd_pkg::NUM_SECTIONS; s++) begin
      cnt_view[s] = cnt_r[s];
    end
    if (phase_e == cdrd_pkg::PH_CNT3) begin
      cnt_view[cdrd_pkg::NUM_SECTIONS-1] = head.value;
    end
    from = phase_e[cdrd_pkg::SEC_W] ? {1'b0, sec} + 1'b1 : '0;
    sel_found = 1'b0;
    sel_sec   = '0;
    sel_cnt   = '0;
    for (int s = cdrd_pkg::NUM_SECTIONS - 1; s >= 0; s--) begin
      if (((cdrd_pkg::SEC_W + 1)'(s) >= from) && (cnt_view[s] != '0)) begin
        sel_found = 1'b1;
        sel_sec   = cdrd_pkg::SEC_W'(s);
        sel_cnt   = cnt_view[s];
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    first_nxt   = first_r;
    entries_nxt = entries_r;
    run_nxt     = run_r;
    held_nxt    = held_r;
    cnt_we      = 1'b0;
    cnt_wa      = sec;
    res_load    = 1'b0;
    res_kind    = cdrd_pkg::entry_kind_t'({1'b0, sec});
    res_idx     = run_e;
    res_flags   = held_e;
    res_code    = '0;
    res_done    = 1'b0;

    if (pop && !idle_e) begin
      phase_nxt   = phase_e;
      slot_nxt    = slot_e;
      first_nxt   = first_e;
      entries_nxt = entries_e;
      run_nxt     = run_e;
      held_nxt    = held_e;
      case (phase_e)
        cdrd_pkg::PH_CNT0, cdrd_pkg::PH_CNT1, cdrd_pkg::PH_CNT2: begin
          cnt_we    = 1'b1;
          phase_nxt = cdrd_pkg::phase_t'(phase_e + 1'b1);
        end
        cdrd_pkg::PH_CNT3: begin
          cnt_we = 1'b1;
          slot_nxt = cdrd_pkg::SLOT_DELTA;
          if (sel_found) begin
            phase_nxt   = cdrd_pkg::phase_t'({1'b1, sel_sec});
            entries_nxt = sel_cnt;
            first_nxt   = 1'b1;
          end else begin
            phase_nxt   = cdrd_pkg::PH_SEC3;
            entries_nxt = '0;
            res_load    = 1'b1;
            res_kind    = cdrd_pkg::KIND_EMPTY;
            res_idx     = '0;
            res_flags   = '0;
            res_done    = 1'b1;
          end
        end
        default: begin
          case (slot_e)
            cdrd_pkg::SLOT_DELTA: begin
              run_nxt   = first_e ? head.value : run_e + head.value;
              first_nxt = 1'b0;
              slot_nxt  = cdrd_pkg::SLOT_FLAGS;
            end
            cdrd_pkg::SLOT_FLAGS: begin
              held_nxt  = head.value;
              res_flags = head.value;
              // fields end after their flags
              if (!sec[cdrd_pkg::SEC_W-1]) begin
                res_load = 1'b1;
              end else begin
                slot_nxt = cdrd_pkg::SLOT_CODE;
              end
            end
            default: begin
              res_code = head.value;
              res_load = 1'b1;
            end
          endcase
          if (res_load) begin
            slot_nxt    = cdrd_pkg::SLOT_DELTA;
            entries_nxt = entries_e - 1'b1;
            if (entries_e == cdrd_pkg::value_t'(1)) begin
              if (sel_found) begin
                phase_nxt   = cdrd_pkg::phase_t'({1'b1, sel_sec});
                entries_nxt = sel_cnt;
                first_nxt   = 1'b1;
              end else begin
                phase_nxt = cdrd_pkg::PH_SEC3;
                res_done  = 1'b1;
              end
            end
          end
        end
      endcase
    end else if (pop && head.start) begin
      // unreachable: a record start is never idle
      phase_nxt = phase_e;
    end

    ov_nxt = res_load ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cdrd_pkg::PH_CNT0;
      slot_r    <= cdrd_pkg::SLOT_DELTA;
      first_r   <= 1'b0;
      entries_r <= '0;
      run_r     <= '0;
      held_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      slot_r    <= slot_nxt;
      first_r   <= first_nxt;
      entries_r <= entries_nxt;
      run_r     <= run_nxt;
      held_r    <= held_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_r[cnt_wa] <= head.value;
    end
    if (res_load) begin
      kind_r  <= res_kind;
      idx_r   <= res_idx;
      flags_r <= res_flags;
      code_r  <= res_code;
      done_r  <= res_done;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.entry_kind   = kind_r;
  assign out_ch.member_index = idx_r;
  assign out_ch.member_flags = flags_r;
  assign out_ch.code_offset  = code_r;
  assign out_ch.record_done  = done_r;

  assign b_stat.idle      = (phase_r == cdrd_pkg::PH_SEC3) && (entries_r == '0);
  assign b_stat.load      = res_load;
  assign b_stat.load_done = res_done;

endmodule

// File: rtl/class_data_record_decoder_unit.sv
// ----------------------------------------------------------------------------
// Class-data record decoder
// Decodes a byte stream of class-data records into field and method entries.
// ----------------------------------------------------------------------------
// in_ch takes one record byte per item, with record_start high on the first
// byte of a record. out_ch gives one item per finished field or method
// entry (kind, absolute index, flags, code offset), or one empty-record item
// when all four section counts are zero; record_done marks the last item.
// Throughput is one byte per cycle while out_ch accepts items: the LEB128
// front end and the record walker each take one step per cycle, joined by a
// two-entry value queue. The value that ends an entry enters the queue when
// its last byte is accepted; the walker then pops it and loads the entry
// result into the output register.
// After reset decoding starts as if a record had begun. Bytes that follow a
// finished record are dropped until the next record start.
// When out_ch stalls, the output register holds its item, the walker stops
// and the queue fills; in_ch.ready drops once the queue is full, so no
// item is lost.
// ----------------------------------------------------------------------------
`include "class_data_record_decoder_unit_defines.svh"

module class_data_record_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  cdrd_in_if.sink     in_ch,
  cdrd_out_if.source  out_ch
);

  logic                   push, pop;
  cdrd_pkg::value_entry_t push_data, head;
  cdrd_pkg::fifo_stat_t   q_stat;
  cdrd_pkg::back_stat_t   b_stat;
  logic                   out_is_empty;

  cdrd_leb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  cdrd_value_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cdrd_walk_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch),
    .b_stat (b_stat)
  );

  assign out_is_empty = out_ch.valid && (out_ch.entry_kind == cdrd_pkg::KIND_EMPTY);

  `CDRD_ASSERT_SAME(a_no_push_when_full, push, !q_stat.full)
  `CDRD_ASSERT_NEXT(a_done_leaves_idle, b_stat.load && b_stat.load_done, b_stat.idle)
  `CDRD_ASSERT_SAME(a_empty_is_last, out_is_empty, out_ch.record_done)

endmodule
